[sv/mnea_pkg.sv]
// ----------------------------------------------------------------------------
// mnea_pkg
// shared request codes, field widths and controller interface types
// ----------------------------------------------------------------------------
package mnea_pkg;

  localparam int REQ_W     = 2;
  localparam int NODE_W    = 3;
  localparam int CODE_W    = 8;
  localparam int CNT_W     = 7;
  localparam int BUSY_W    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_RAISE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SOLVE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd127;
  localparam logic [BUSY_W-1:0] BUSY_MAX = 4'd15;

  typedef struct packed {
    logic capture;
    logic execute;
  } mnea_cmd_t;

  typedef struct packed {
    logic out_stall;
  } mnea_stat_t;

endpackage

[sv/mnea_ctrl.sv]
// ----------------------------------------------------------------------------
// mnea_ctrl
// request sequencer: takes one request, runs its update, hands off the result
// ----------------------------------------------------------------------------
module mnea_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output mnea_pkg::mnea_cmd_t  cmd,
  input  mnea_pkg::mnea_stat_t stat
);
  import mnea_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stat.out_stall) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/mnea_dp.sv]
// ----------------------------------------------------------------------------
// mnea_dp
// node code store, global counters and result register
// ----------------------------------------------------------------------------
module mnea_dp #(
  parameter int NODE_COUNT = 8,
  parameter int CODE_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mnea_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [mnea_pkg::IN_USER_W-1:0] in_tuser,
  input  mnea_pkg::mnea_cmd_t            cmd,
  output mnea_pkg::mnea_stat_t           stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mnea_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mnea_pkg::*;

  localparam int NUM_CODES  = CODE_BYTES * 8;
  localparam int BIT_W      = $clog2(NUM_CODES);
  localparam int NODE_DEPTH = (NODE_COUNT < 8) ? NODE_COUNT : 8;
  localparam int IDX_W      = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

  logic [NUM_CODES-1:0] bitmap_r [NODE_DEPTH];
  logic [CNT_W-1:0]     count_r  [NODE_DEPTH];
  logic [BUSY_W-1:0]    busy_r, busy_nxt;
  logic                 led_r, led_nxt;

  logic [REQ_W-1:0]  req_r;
  logic [NODE_W-1:0] node_r;
  logic [CODE_W-1:0] code_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 node_ok, code_ok, hit, status;
  logic [IDX_W-1:0]     idx;
  logic [NUM_CODES-1:0] mask, bm_cur, bm_nxt;
  logic [CNT_W-1:0]     cnt_cur, cnt_nxt, cnt_out;

  assign node_ok = {4'b0, node_r} < 7'(NODE_COUNT);
  assign code_ok = {1'b0, code_r} < 9'(NUM_CODES);
  assign idx     = node_r[IDX_W-1:0];
  assign mask    = {{(NUM_CODES-1){1'b0}}, 1'b1} << code_r[BIT_W-1:0];
  assign bm_cur  = node_ok ? bitmap_r[idx] : '0;
  assign cnt_cur = node_ok ? count_r[idx] : '0;
  assign hit     = |(bm_cur & mask);

  always_comb begin
    bm_nxt   = bm_cur;
    cnt_nxt  = cnt_cur;
    busy_nxt = busy_r;
    led_nxt  = led_r;
    status   = 1'b0;
    if (node_ok) begin
      unique case (req_r)
        REQ_RAISE: begin
          if (!code_ok) begin
            status = 1'b1;
          end else begin
            if (!hit) begin
              bm_nxt = bm_cur | mask;
              if (cnt_cur == '0 && busy_r != BUSY_MAX) busy_nxt = busy_r + 1'b1;
              if (cnt_cur != CNT_MAX) cnt_nxt = cnt_cur + 1'b1;
            end
            led_nxt = 1'b1;
          end
        end
        REQ_SOLVE: begin
          if (!code_ok) begin
            status = 1'b1;
          end else if (hit) begin
            bm_nxt = bm_cur & ~mask;
            if (cnt_cur != '0) cnt_nxt = cnt_cur - 1'b1;
            if (cnt_nxt == '0) begin
              if (busy_r != '0) busy_nxt = busy_r - 1'b1;
              if (busy_nxt == '0) led_nxt = 1'b0;
            end
          end
        end
        REQ_RELEASE: begin
          if (cnt_cur != '0) begin
            if (busy_r != '0) busy_nxt = busy_r - 1'b1;
            if (busy_nxt == '0) led_nxt = 1'b0;
          end
          bm_nxt  = '0;
          cnt_nxt = '0;
        end
        REQ_QUERY: begin
        end
        default: begin
        end
      endcase
    end
    cnt_out = node_ok ? cnt_nxt : '0;
    // status, active, led, node count, busy nodes
    out_data_nxt = {2'b00, busy_nxt, cnt_out, led_nxt,
                    (cnt_out != '0) || (busy_nxt != '0), status};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_tuser;
      node_r <= in_tdata[NODE_W-1:0];
      code_r <= in_tdata[NODE_W +: CODE_W];
    end
    if (cmd.execute) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_DEPTH; i++) begin
        bitmap_r[i] <= '0;
        count_r[i]  <= '0;
      end
      busy_r      <= '0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.execute) begin
        if (node_ok) begin
          bitmap_r[idx] <= bm_nxt;
          count_r[idx]  <= cnt_nxt;
        end
        busy_r      <= busy_nxt;
        led_r       <= led_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_stall = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;

endmodule

[sv/multi_node_emergency_aggregator.sv]
// ----------------------------------------------------------------------------
// multi_node_emergency_aggregator
// per-node emergency code tracking with a global busy count and latched led
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the in_ stream; in_tuser carries the request kind
//   (raise, solve, release, query), in_tdata the node and the code.
//   every request yields exactly one response on the out_ stream with the
//   status, the emergency flag, the led, the node's code count and the
//   number of busy nodes, all as they stand after the request.
//   a request is captured in the idle state and its update runs in the exec
//   state, which writes the response register with it; the sequencer takes
//   no new request before the current one has executed.
//   a response waits in the output register while out_tready is low; the
//   next request may still be taken, and its update waits until the held
//   response is taken.
//   reset (rst_n low, synchronous) clears every node's bitmap and count, the
//   busy count, the led and the output valid.
// ----------------------------------------------------------------------------
module multi_node_emergency_aggregator #(
  parameter int NODE_COUNT = 8,
  parameter int CODE_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node_index[2:0], exception_code[10:3], zero fill
  input  logic [mnea_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [mnea_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[0], emergency_active[1], led_on[2], node_code_count[9:3],
  // nodes_in_emergency[13:10], zero fill
  output logic [mnea_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mnea_pkg::*;

  mnea_cmd_t  cmd;
  mnea_stat_t stat;

  mnea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mnea_dp #(
    .NODE_COUNT (NODE_COUNT),
    .CODE_BYTES (CODE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
